@@ rtl/core/rrts_pkg.sv @@
// Package with types and constants of the round robin task scheduler.
package rrts_pkg;

	typedef enum logic [1:0] {
		OP_CREATE   = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_FINISH   = 2'd2,
		OP_UNKNOWN  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CALL_NONE   = 3'd0,
		CALL_ID     = 3'd1,
		CALL_PRIO   = 3'd2,
		CALL_RUN    = 3'd3,
		CALL_READ   = 3'd4,
		CALL_SLEEP  = 3'd5,
		CALL_USAGE  = 3'd6,
		CALL_UNSUPP = 3'd7
	} call_t;

	typedef enum logic [1:0] {
		TS_NONE  = 2'd0,
		TS_READY = 2'd1,
		TS_BLOCK = 2'd2,
		TS_RUN   = 2'd3
	} tstate_t;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_NONE = 2'd2;

	localparam logic [6:0] USAGE_SCALE = 7'd100;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] now;
		logic [7:0]  priority_req;
		logic [2:0]  call_code;
		logic [30:0] sleep_ticks;
		logic [7:0]  read_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  task_index;
		logic [31:0] value;
		logic [1:0]  status;
	} out_item_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_CREATE,
		CS_WAKE,
		CS_PICK,
		CS_FIN_CHARGE,
		CS_FIN_CALL,
		CS_DIV,
		CS_DIV_DONE,
		CS_UNKNOWN,
		CS_OUT
	} cstate_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic create_do;
		logic wake_do;
		logic pick_do;
		logic pick_commit;
		logic charge_do;
		logic call_do;
		logic div_start;
		logic div_step;
		logic div_finish;
		logic unknown_do;
		logic out_take;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic pick_found;
		logic div_done;
	} sts_t;

endpackage

@@ rtl/core/rrts_ctrl.sv @@
// Controller state machine of the round robin task scheduler.
module rrts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic [1:0]    op,
	output rrts_pkg::cmd_t cmd,
	input  rrts_pkg::sts_t sts
);
	import rrts_pkg::*;

	cstate_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					unique case (op_t'(op))
						OP_CREATE:   state_d = CS_CREATE;
						OP_DISPATCH: state_d = CS_WAKE;
						OP_FINISH:   state_d = CS_FIN_CHARGE;
						default:     state_d = CS_UNKNOWN;
					endcase
				end
			end
			CS_CREATE: begin
				cmd.create_do = 1'b1;
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = CS_OUT;
			end
			CS_WAKE: begin
				cmd.wake_do = 1'b1;
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					cmd.scan_clr = 1'b1;
					cmd.scan_step = 1'b0;
					state_d = CS_PICK;
				end
			end
			CS_PICK: begin
				cmd.pick_do = 1'b1;
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					cmd.pick_commit = 1'b1;
					state_d = CS_OUT;
				end
			end
			CS_FIN_CHARGE: begin
				cmd.charge_do = 1'b1;
				state_d = CS_FIN_CALL;
			end
			CS_FIN_CALL: begin
				cmd.call_do = 1'b1;
				if (sts.div_done) begin
					state_d = CS_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d = CS_DIV;
				end
			end
			CS_DIV: begin
				if (sts.div_done) begin
					state_d = CS_DIV_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			CS_DIV_DONE: begin
				cmd.div_finish = 1'b1;
				state_d = CS_OUT;
			end
			CS_UNKNOWN: begin
				cmd.unknown_do = 1'b1;
				state_d = CS_OUT;
			end
			CS_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_take = 1'b1;
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while a result is held");
	a_out_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready) else $error("no return to idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_valid) else $error("load without a beat");
`endif

endmodule

@@ rtl/core/rrts_dp.sv @@
// Datapath of the round robin task scheduler: task table, scans and divider.
module rrts_dp #(
	parameter int TASK_SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rrts_pkg::in_item_t in_item,
	input  rrts_pkg::cmd_t     cmd,
	output rrts_pkg::sts_t     sts,
	output rrts_pkg::out_item_t out_item
);
	import rrts_pkg::*;

	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);

	logic [TASK_SLOTS-1:0] used_q;
	tstate_t               tstate_q [TASK_SLOTS];
	logic [7:0]            prio_q   [TASK_SLOTS];
	logic [31:0]           run_q    [TASK_SLOTS];
	logic [31:0]           wake_q   [TASK_SLOTS];
	logic [SW-1:0]         cur_q;
	logic [31:0]           disp_q;

	in_item_t      item_q;
	logic [SW-1:0] scan_q;
	logic          found_q;
	logic [SW-1:0] pick_q;
	out_item_t     res_q;

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [6:0]  cnt_q;
	logic        div_done_q;

	logic [SW-1:0] rr_slot;
	logic [SW:0]   rr_sum;
	logic [31:0]   cur_run;
	logic [31:0]   cur_id;
	logic [64:0]   trial;

	assign rr_sum  = {1'b0, cur_q} + {1'b0, scan_q} + 1'b1;
	assign rr_slot = (rr_sum >= (SW+1)'(TASK_SLOTS)) ?
		SW'(rr_sum - (SW+1)'(TASK_SLOTS)) : SW'(rr_sum);
	assign cur_run = run_q[cur_q];
	assign cur_id  = used_q[cur_q] ? 32'({1'b0, cur_q} + 1'b1) : 32'd0;
	assign trial   = {rem_q, quo_q[63]} - {33'd0, item_q.now};

	assign sts.scan_last  = (scan_q == LAST);
	assign sts.pick_found = found_q;
	assign sts.div_done   = div_done_q;
	assign out_item = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				tstate_q[i] <= TS_NONE;
				prio_q[i] <= '0;
				run_q[i] <= '0;
				wake_q[i] <= '0;
			end
			cur_q <= LAST;
			disp_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
			pick_q <= '0;
			div_done_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			res_q <= '0;
		end else begin
			if (cmd.scan_clr) begin
				scan_q <= '0;
				found_q <= 1'b0;
				pick_q <= '0;
				div_done_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + 1'b1;
			end

			if (cmd.create_do) begin
				if (!found_q && !used_q[scan_q]) begin
					found_q <= 1'b1;
					used_q[scan_q] <= 1'b1;
					tstate_q[scan_q] <= TS_READY;
					prio_q[scan_q] <= item_q.priority_req;
					res_q <= '{task_index: 3'(scan_q),
						value: 32'({1'b0, scan_q} + 1'b1), status: STAT_OK};
				end else if (!found_q && sts.scan_last) begin
					res_q <= '{task_index: 3'd0, value: 32'd0, status: STAT_FULL};
				end
			end

			if (cmd.wake_do && scan_q != '0 && tstate_q[scan_q] == TS_BLOCK &&
					wake_q[scan_q] <= item_q.now) begin
				tstate_q[scan_q] <= TS_READY;
				wake_q[scan_q] <= '0;
			end

			if (cmd.pick_do) begin
				if (!found_q && rr_slot != '0 && tstate_q[rr_slot] == TS_READY) begin
					found_q <= 1'b1;
					pick_q <= rr_slot;
				end
				if (cmd.pick_commit) begin
					logic [SW-1:0] p;
					p = (!found_q && rr_slot != '0 && tstate_q[rr_slot] == TS_READY) ?
						rr_slot : pick_q;
					tstate_q[p] <= TS_RUN;
					cur_q <= p;
					disp_q <= item_q.now;
					res_q <= '{task_index: 3'(p),
						value: used_q[p] ? 32'({1'b0, p} + 1'b1) : 32'd0,
						status: STAT_OK};
				end
			end

			if (cmd.charge_do) begin
				run_q[cur_q] <= cur_run + (item_q.now - disp_q);
				div_done_q <= (call_t'(item_q.call_code) != CALL_USAGE) ||
					(item_q.now == '0);
			end

			if (cmd.call_do) begin
				res_q.task_index <= 3'(cur_q);
				unique case (call_t'(item_q.call_code))
					CALL_ID: begin
						res_q.value <= cur_id;
						res_q.status <= STAT_OK;
					end
					CALL_PRIO: begin
						res_q.value <= 32'(prio_q[cur_q]);
						res_q.status <= STAT_OK;
					end
					CALL_RUN: begin
						res_q.value <= cur_run;
						res_q.status <= STAT_OK;
					end
					CALL_READ: begin
						res_q.value <= 32'(item_q.read_byte);
						res_q.status <= STAT_OK;
					end
					CALL_SLEEP: begin
						res_q.value <= '0;
						res_q.status <= STAT_NONE;
						if (used_q[cur_q]) begin
							wake_q[cur_q] <= item_q.now + {1'b0, item_q.sleep_ticks};
							tstate_q[cur_q] <= TS_BLOCK;
						end
					end
					CALL_USAGE: begin
						res_q.value <= '0;
						res_q.status <= STAT_OK;
					end
					default: begin
						res_q.value <= '0;
						res_q.status <= STAT_NONE;
					end
				endcase
				if (used_q[cur_q] && tstate_q[cur_q] == TS_RUN &&
						call_t'(item_q.call_code) != CALL_SLEEP)
					tstate_q[cur_q] <= TS_READY;
			end

			if (cmd.div_start) begin
				rem_q <= '0;
				quo_q <= 64'(run_q[0]) * 64'(USAGE_SCALE);
				cnt_q <= '0;
			end

			if (cmd.div_step) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 7'd63) div_done_q <= 1'b1;
			end

			if (cmd.div_finish) begin
				res_q.value <= (quo_q > 64'(USAGE_SCALE)) ? 32'd0 :
					32'(USAGE_SCALE) - quo_q[31:0];
			end

			if (cmd.unknown_do) begin
				res_q <= '{task_index: 3'd0, value: 32'd0, status: STAT_NONE};
			end
		end
	end

`ifndef SYNTHESIS
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < TASK_SLOTS) else $error("current slot out of range");
	a_cur_running: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick_commit |=> tstate_q[cur_q] == TS_RUN) else $error("pick not running");
	a_slot0_never_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(tstate_q[0] != TS_BLOCK) || used_q[0]) else $error("unused idle slot blocked");
`endif

endmodule

@@ rtl/core/round_robin_task_scheduler_core.sv @@
// Top level of the round robin task scheduler core.
// The input channel carries one operation per beat: create a task, dispatch
// the next task, or finish the running task's slice with a system call.
// The output channel returns one result beat per input beat with the slot,
// a value and a status.
// Operations are handled one at a time by a controller and datapath pair.
// Create scans the slot table one slot per cycle.
// Dispatch scans twice, once to wake sleepers and once round robin.
// Finish charges the running slot's time and answers the call; a CPU usage
// call also runs a bit serial 64-bit divider one quotient bit per cycle.
// The result is held in a register until the receiver takes it; while the
// receiver stalls, no new beat is accepted.
// Reset clears the task table, sets the current slot to the last slot and
// the dispatch time to zero; the block is ready right after reset.
// The CPU usage figure is 100 minus the idle slot's share of uptime in percent.
module round_robin_task_scheduler_core #(
	parameter int TASK_SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rrts_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rrts_pkg::out_item_t out_data
);
	import rrts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rrts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.op(in_data.operation), .cmd(cmd), .sts(sts)
	);

	rrts_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_data), .cmd(cmd), .sts(sts), .out_item(out_data)
	);

endmodule

@@ tb/sv/tb_round_robin_task_scheduler_checker.sv @@
// Checker for the round robin task scheduler: predicts each result and compares it.
module tb_round_robin_task_scheduler_checker
	import rrts_pkg::*;
#(
	parameter int TASK_SLOTS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic        used_q [TASK_SLOTS];
	tstate_t     state_q [TASK_SLOTS];
	logic [7:0]  prio_q [TASK_SLOTS];
	logic [31:0] run_q [TASK_SLOTS];
	logic [31:0] wake_q [TASK_SLOTS];
	int          cur_slot;
	logic [31:0] disp_tick;
	out_item_t   expected_results[$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic out_item_t schedule_step(input in_item_t it);
		out_item_t r;
		int s;
		int pick;
		logic [63:0] q;
		r = '0;
		case (op_t'(it.operation))
			OP_CREATE: begin
				r.status = STAT_FULL;
				for (s = 0; s < TASK_SLOTS; s++) begin
					if (!used_q[s]) begin
						used_q[s] = 1'b1;
						state_q[s] = TS_READY;
						prio_q[s] = it.priority_req;
						r.task_index = 3'(s);
						r.value = 32'(s + 1);
						r.status = STAT_OK;
						break;
					end
				end
			end
			OP_DISPATCH: begin
				for (s = 1; s < TASK_SLOTS; s++) begin
					if (state_q[s] == TS_BLOCK && wake_q[s] <= it.now) begin
						state_q[s] = TS_READY;
						wake_q[s] = '0;
					end
				end
				pick = 0;
				for (int i = 1; i <= TASK_SLOTS; i++) begin
					s = (cur_slot + i) % TASK_SLOTS;
					if (s != 0 && state_q[s] == TS_READY) begin
						pick = s;
						break;
					end
				end
				state_q[pick] = TS_RUN;
				cur_slot = pick;
				disp_tick = it.now;
				r.task_index = 3'(pick);
				r.value = used_q[pick] ? 32'(pick + 1) : 32'd0;
				r.status = STAT_OK;
			end
			OP_FINISH: begin
				s = cur_slot;
				run_q[s] = run_q[s] + (it.now - disp_tick);
				r.task_index = 3'(s);
				r.status = STAT_OK;
				case (call_t'(it.call_code))
					CALL_ID: r.value = used_q[s] ? 32'(s + 1) : 32'd0;
					CALL_PRIO: r.value = 32'(prio_q[s]);
					CALL_RUN: r.value = run_q[s];
					CALL_READ: r.value = 32'(it.read_byte);
					CALL_SLEEP: begin
						if (used_q[s]) begin
							wake_q[s] = it.now + {1'b0, it.sleep_ticks};
							state_q[s] = TS_BLOCK;
						end
						r.status = STAT_NONE;
					end
					CALL_USAGE: begin
						if (it.now != 0) begin
							q = (64'(run_q[0]) * 64'(USAGE_SCALE)) / 64'(it.now);
							r.value = (q > 64'(USAGE_SCALE)) ? 32'd0 :
								32'(64'(USAGE_SCALE) - q);
						end
					end
					default: r.status = STAT_NONE;
				endcase
				if (used_q[s] && state_q[s] == TS_RUN)
					state_q[s] = TS_READY;
			end
			default: r.status = STAT_NONE;
		endcase
		return r;
	endfunction

	assign pending_count = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int s = 0; s < TASK_SLOTS; s++) begin
				used_q[s] = 1'b0;
				state_q[s] = TS_NONE;
				prio_q[s] = '0;
				run_q[s] = '0;
				wake_q[s] = '0;
			end
			cur_slot = TASK_SLOTS - 1;
			disp_tick = '0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected beat index", 32'(out_data.task_index),
						32'd0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.task_index !== want.task_index)
						report_mismatch("task_index", 32'(out_data.task_index),
							32'(want.task_index));
					if (out_data.value !== want.value)
						report_mismatch("value", out_data.value, want.value);
					if (out_data.status !== want.status)
						report_mismatch("status", 32'(out_data.status), 32'(want.status));
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(schedule_step(in_data));
		end
	end
endmodule

@@ tb/sv/tb_round_robin_task_scheduler_core.sv @@
// Testbench top: drives operations into the scheduler core and gives the verdict.
module tb_round_robin_task_scheduler_core;
	import rrts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	int        fail_count;
	int        pending_count;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        quiet_cycles = 0;
	int        beats_sent = 0;
	logic [31:0] uptime = 0;

	always #1 clk = ~clk;

	round_robin_task_scheduler_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	tb_round_robin_task_scheduler_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_beat(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	function automatic in_item_t make_op(input op_t op, input logic [31:0] now,
			input call_t code);
		in_item_t it;
		it.operation = op;
		it.now = now;
		it.priority_req = 8'($urandom_range(255));
		it.call_code = code;
		it.sleep_ticks = 31'($urandom());
		it.read_byte = 8'($urandom_range(255));
		return it;
	endfunction

	function automatic in_item_t random_op();
		int pick;
		call_t code;
		pick = $urandom_range(99);
		uptime = uptime + $urandom_range(50);
		code = call_t'($urandom_range(7));
		if (pick < 15)
			return make_op(OP_CREATE, uptime, code);
		if (pick < 50)
			return make_op(OP_DISPATCH, uptime, code);
		if (pick < 95) begin
			random_op = make_op(OP_FINISH, uptime, code);
			if (code == CALL_SLEEP)
				random_op.sleep_ticks = ($urandom_range(3) == 0) ? 31'($urandom()) :
					31'($urandom_range(200));
			return random_op;
		end
		random_op = make_op(OP_UNKNOWN, $urandom(), code);
	endfunction

	initial begin
		in_item_t it;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(make_op(OP_DISPATCH, 32'd0, CALL_NONE));
		send_beat(make_op(OP_FINISH, 32'd0, CALL_USAGE));
		send_beat(make_op(OP_FINISH, 32'd5, CALL_ID));
		it = make_op(OP_CREATE, 32'd6, CALL_NONE);
		it.priority_req = 8'hff;
		send_beat(it);
		it.priority_req = 8'h00;
		repeat (8) send_beat(it);
		send_beat(make_op(OP_DISPATCH, 32'd10, CALL_NONE));
		send_beat(make_op(OP_FINISH, 32'd20, CALL_PRIO));
		send_beat(make_op(OP_DISPATCH, 32'd20, CALL_NONE));
		it = make_op(OP_FINISH, 32'hffffffff, CALL_READ);
		it.read_byte = 8'hff;
		send_beat(it);
		send_beat(make_op(OP_DISPATCH, 32'hffffffff, CALL_NONE));
		it = make_op(OP_FINISH, 32'hfffffff0, CALL_SLEEP);
		it.sleep_ticks = 31'h7fffffff;
		send_beat(it);
		send_beat(make_op(OP_FINISH, 32'd1, CALL_RUN));
		send_beat(make_op(OP_FINISH, 32'd1, CALL_USAGE));
		send_beat(make_op(OP_FINISH, 32'hffffffff, CALL_USAGE));
		send_beat(make_op(OP_FINISH, 32'd3, CALL_UNSUPP));
		it = make_op(OP_UNKNOWN, 32'hffffffff, CALL_UNSUPP);
		it.sleep_ticks = 31'h7fffffff;
		it.read_byte = 8'hff;
		send_beat(it);
		uptime = 32'd100;

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 53 : (phase == 3) ? 29 : 0;
			recv_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 29 : 0;
			repeat (100) send_beat(random_op());
		end
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d operations: create, dispatch, finish with every call, unknown,",
			beats_sent);
		$display("under four idle and stall patterns.");
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
